// ===== src/rcdc_pkg.sv =====
// Shared constants and the remainder-to-character map for the radix-11 unpacker.
`timescale 1ns / 1ps
`default_nettype none

package rcdc_pkg;

    localparam int CODE_W    = 32;
    localparam int CHAR_W    = 8;
    localparam int REM_W     = 4;
    localparam int MAX_CHARS = 10;                 // 11^10 > 2^32
    localparam int IDX_W     = $clog2(MAX_CHARS);
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);

    // Reciprocal of 11: q = (x * DIV_MAGIC) >> DIV_SHIFT, exact for all 32-bit x.
    localparam logic [CODE_W-1:0] DIV_MAGIC = 32'hBA2E_8BA3;
    localparam int DIV_SHIFT = 35;
    localparam int PROD_W    = 2 * CODE_W;
    localparam int QUOT_W    = PROD_W - DIV_SHIFT;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    // Remainder 0 is a space, 1..10 map to '0'..'9'.
    function automatic logic [CHAR_W-1:0] rem_to_char(input logic [REM_W-1:0] rem);
        logic [CHAR_W-1:0] ch;
        if (rem == '0)
            ch = CHAR_SPACE;
        else
            ch = CHAR_ZERO + CHAR_W'(rem) - CHAR_W'(1);
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== src/rcdc_div11.sv =====
// Shared divide-by-11 unit: registered reciprocal product, then quotient and remainder.
`timescale 1ns / 1ps
`default_nettype none

module rcdc_div11
(
    input  wire logic                          clk,
    input  wire logic [rcdc_pkg::CODE_W-1:0]   dividend,
    output logic      [rcdc_pkg::CODE_W-1:0]   quotient,
    output logic      [rcdc_pkg::REM_W-1:0]    remainder
);

    logic [rcdc_pkg::PROD_W-1:0] product_reg;
    logic [rcdc_pkg::CODE_W-1:0] dividend_reg;
    logic [rcdc_pkg::QUOT_W-1:0] quot;
    logic [rcdc_pkg::CODE_W-1:0] quot_ext;
    logic [rcdc_pkg::CODE_W-1:0] quot_x11;
    logic [rcdc_pkg::CODE_W-1:0] diff;

    always_ff @(posedge clk)
    begin
        product_reg  <= rcdc_pkg::PROD_W'(dividend) * rcdc_pkg::PROD_W'(rcdc_pkg::DIV_MAGIC);
        dividend_reg <= dividend;
    end

    // q*11 as q*8 + q*2 + q
    always_comb
    begin
        quot      = product_reg[rcdc_pkg::PROD_W-1:rcdc_pkg::DIV_SHIFT];
        quot_ext  = rcdc_pkg::CODE_W'(quot);
        quot_x11  = (quot_ext << 3) + (quot_ext << 1) + quot_ext;
        diff      = dividend_reg - quot_x11;
        quotient  = quot_ext;
        remainder = diff[rcdc_pkg::REM_W-1:0];
    end

endmodule

`default_nettype wire

// ===== src/rcdc_digit_store.sv =====
// Small register stack of remainders, written low digit first and read back as characters.
`timescale 1ns / 1ps
`default_nettype none

module rcdc_digit_store
(
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [rcdc_pkg::IDX_W-1:0]    wr_idx,
    input  wire logic [rcdc_pkg::REM_W-1:0]    wr_rem,
    input  wire logic [rcdc_pkg::IDX_W-1:0]    rd_idx,
    output logic      [rcdc_pkg::CHAR_W-1:0]   rd_char
);

    logic [rcdc_pkg::REM_W-1:0] digit_reg [rcdc_pkg::MAX_CHARS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            digit_reg[wr_idx] <= wr_rem;
        end
    end

    assign rd_char = rcdc_pkg::rem_to_char(digit_reg[rd_idx]);

endmodule

`default_nettype wire

// ===== src/radix11_code_to_digit_chars.sv =====
// Top level: unpacks a 32-bit code into radix-11 characters, most significant first.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------------
//   code    | in        | code_valid / code_stall | packed_code[31:0]
//   char    | out       | char_valid / char_stall | char_code[7:0], empty_string, last_char
//
// Sequence: each of the 1..10 digits passes through the shared divide-by-11
//   unit in ST_MUL (product register), then ST_DIV (quotient/remainder), then
//   the characters go out one per cycle unless char_stall holds them; zero uses ST_ZERO.
// The block holds code_stall high from acceptance until the last character
//   is loaded into the output register; it takes the next request while that
//   character still waits for the sink.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
// A stall on the char channel holds the output register and pauses emission.
`timescale 1ns / 1ps
`default_nettype none

module radix11_code_to_digit_chars
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           code_valid,
    output logic                                code_stall,
    input  wire logic [rcdc_pkg::CODE_W-1:0]    packed_code,

    output logic                                char_valid,
    input  wire logic                           char_stall,
    output logic      [rcdc_pkg::CHAR_W-1:0]    char_code,
    output logic                                empty_string,
    output logic                                last_char
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_EMIT,
        ST_ZERO
    } state_t;

    state_t                          state_reg, state_next;
    logic [rcdc_pkg::CODE_W-1:0]     value_reg, value_next;
    logic [rcdc_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [rcdc_pkg::IDX_W-1:0]      emit_idx_reg, emit_idx_next;
    logic                            char_valid_reg, char_valid_next;
    logic [rcdc_pkg::CHAR_W-1:0]     char_code_reg, char_code_next;
    logic                            empty_reg, empty_next;
    logic                            last_reg, last_next;

    logic [rcdc_pkg::CODE_W-1:0]     div_quot;
    logic [rcdc_pkg::REM_W-1:0]      div_rem;
    logic                            dig_wr_en;
    logic [rcdc_pkg::CHAR_W-1:0]     stack_char;
    logic                            slot_free;
    logic                            accept;

    // Shared divider: always works on value_reg; results valid in ST_DIV.
    rcdc_div11 u_div11
    (
        .clk       (clk),
        .dividend  (value_reg),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    rcdc_digit_store u_digit_store
    (
        .clk     (clk),
        .wr_en   (dig_wr_en),
        .wr_idx  (count_reg[rcdc_pkg::IDX_W-1:0]),
        .wr_rem  (div_rem),
        .rd_idx  (emit_idx_reg),
        .rd_char (stack_char)
    );

    assign code_stall = (state_reg != ST_IDLE);
    assign accept     = code_valid && !code_stall;
    assign slot_free  = !char_valid_reg || !char_stall;
    assign dig_wr_en  = (state_reg == ST_DIV);

    always_comb
    begin
        state_next      = state_reg;
        value_next      = value_reg;
        count_next      = count_reg;
        emit_idx_next   = emit_idx_reg;
        char_valid_next = char_valid_reg;
        char_code_next  = char_code_reg;
        empty_next      = empty_reg;
        last_next       = last_reg;

        // Output register empties when the sink takes it.
        if (char_valid_reg && !char_stall)
        begin
            char_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    value_next = packed_code;
                    count_next = '0;
                    if (packed_code == '0)
                        state_next = ST_ZERO;
                    else
                        state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // Remainder written to the stack at count_reg this cycle.
                value_next = div_quot;
                count_next = count_reg + rcdc_pkg::CNT_W'(1);
                if (div_quot == '0)
                begin
                    emit_idx_next = count_reg[rcdc_pkg::IDX_W-1:0];
                    state_next    = ST_EMIT;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    char_valid_next = 1'b1;
                    char_code_next  = stack_char;
                    empty_next      = 1'b0;
                    last_next       = (emit_idx_reg == '0);
                    if (emit_idx_reg == '0)
                        state_next = ST_IDLE;
                    else
                        emit_idx_next = emit_idx_reg - rcdc_pkg::IDX_W'(1);
                end
            end
            ST_ZERO:
            begin
                if (slot_free)
                begin
                    char_valid_next = 1'b1;
                    char_code_next  = rcdc_pkg::CHAR_NONE;
                    empty_next      = 1'b1;
                    last_next       = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            char_valid_reg <= 1'b0;
            count_reg      <= '0;
            emit_idx_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            char_valid_reg <= char_valid_next;
            count_reg      <= count_next;
            emit_idx_reg   <= emit_idx_next;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        char_code_reg <= char_code_next;
        empty_reg     <= empty_next;
        last_reg      <= last_next;
    end

    assign char_valid   = char_valid_reg;
    assign char_code    = char_code_reg;
    assign empty_string = empty_reg;
    assign last_char    = last_reg;

endmodule

`default_nettype wire
